// File: rtl/core/tpli_pkg.sv
// ----------------------------------------------------------------------------
// tpli_pkg: shared types for the three-point Lagrange interpolator
// Holds the weight sequencer states, the configuration register indexes and
// the status group the weight unit hands to the datapath.
// ----------------------------------------------------------------------------
package tpli_pkg;

  typedef enum logic [2:0] {
    W_CHECK,
    W_PREP,
    W_MUL,
    W_DIV,
    W_ROUND,
    W_IDLE
  } wgt_state_t;

  // Register indexes of the configuration port
  localparam logic [7:0] REG_FIRST_TIME  = 8'd0;
  localparam logic [7:0] REG_SECOND_TIME = 8'd1;
  localparam logic [7:0] REG_THIRD_TIME  = 8'd2;
  localparam logic [7:0] REG_TARGET_TIME = 8'd3;

  typedef struct packed {
    logic ready;    // weights are in place
    logic bad;      // two sample times coincide
    logic clipped;  // a weight was clipped to its range
  } wgt_status_t;

endpackage

// File: rtl/core/tpli_in_if.sv
// ----------------------------------------------------------------------------
// tpli_in_if: sample channel
// Carries the three sampled values of one element with valid/ready.
// ----------------------------------------------------------------------------
interface tpli_in_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value_first;
  logic signed [VALUE_WIDTH-1:0] value_second;
  logic signed [VALUE_WIDTH-1:0] value_third;

  modport source (output valid, value_first, value_second, value_third, input ready);
  modport sink (input valid, value_first, value_second, value_third, output ready);
endinterface

// File: rtl/core/tpli_out_if.sv
// ----------------------------------------------------------------------------
// tpli_out_if: result channel
// Carries one interpolated value and its flags with valid/ready.
// ----------------------------------------------------------------------------
interface tpli_out_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] interpolated_value;
  logic                          saturated;
  logic                          times_invalid;

  modport source (output valid, interpolated_value, saturated, times_invalid, input ready);
  modport sink (input valid, interpolated_value, saturated, times_invalid, output ready);
endinterface

// File: rtl/core/tpli_weights.sv
// ----------------------------------------------------------------------------
// tpli_weights: Lagrange weight sequencer
// Forms the three weights one after another: differences, two products,
// a restoring divider one quotient bit per cycle, then round and clip.
// ----------------------------------------------------------------------------
module tpli_weights
  import tpli_pkg::*;
#(
  parameter int TIME_WIDTH           = 32,
  parameter int WEIGHT_FRACTION_BITS = 30
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic [TIME_WIDTH-1:0]                  first_time,
  input  logic [TIME_WIDTH-1:0]                  second_time,
  input  logic [TIME_WIDTH-1:0]                  third_time,
  input  logic [TIME_WIDTH-1:0]                  target_time,
  output logic signed [WEIGHT_FRACTION_BITS+1:0] weight_first,
  output logic signed [WEIGHT_FRACTION_BITS+1:0] weight_second,
  output logic signed [WEIGHT_FRACTION_BITS+1:0] weight_third,
  output wgt_status_t                            status
);

  localparam int WW        = WEIGHT_FRACTION_BITS + 2;
  localparam int QW        = WEIGHT_FRACTION_BITS + 4;
  localparam int PW        = 2 * TIME_WIDTH;
  localparam int DIV_STEPS = PW + WEIGHT_FRACTION_BITS + 1;
  localparam int CW        = $clog2(DIV_STEPS + 1);

  wgt_state_t state, state_next;

  logic [1:0]            k;
  logic [TIME_WIDTH-1:0] x1, x2, y1, y2;
  logic                  neg;
  logic [PW-1:0]         num, den, rem;
  logic [QW-1:0]         q;
  logic                  over;
  logic [CW-1:0]         cnt;
  logic                  bad, clipped;

  logic [TIME_WIDTH-1:0] ts, ta, tb;
  logic [PW:0]           rem_sh;
  logic                  qb;
  logic [QW-1:0]         q_sh;
  logic [QW:0]           q_inc;
  logic [QW-1:0]         mag, cap, mag_lim;
  logic                  clip_now;
  logic [WW-1:0]         wval;

  // Pick the sample of interest and the two others
  always_comb begin
    case (k)
      2'd0: begin
        ts = first_time;  ta = second_time; tb = third_time;
      end
      2'd1: begin
        ts = second_time; ta = first_time;  tb = third_time;
      end
      default: begin
        ts = third_time;  ta = first_time;  tb = second_time;
      end
    endcase
  end

  always_comb begin
    rem_sh   = {rem, num[PW-1]};
    qb       = rem_sh >= {1'b0, den};
    q_sh     = {q[QW-2:0], qb};
    q_inc    = {1'b0, q} + {{QW{1'b0}}, 1'b1};
    mag      = q_inc[QW:1];
    cap      = neg ? (QW'(1) << (WEIGHT_FRACTION_BITS + 1))
                   : ((QW'(1) << (WEIGHT_FRACTION_BITS + 1)) - QW'(1));
    clip_now = over || (mag > cap);
    mag_lim  = clip_now ? cap : mag;
    wval     = neg ? WW'(-mag_lim) : mag_lim[WW-1:0];
  end

  always_comb begin
    state_next = state;
    case (state)
      W_CHECK: state_next = ((first_time == second_time) || (first_time == third_time) ||
                             (second_time == third_time)) ? W_IDLE : W_PREP;
      W_PREP:  state_next = W_MUL;
      W_MUL:   state_next = W_DIV;
      W_DIV:   state_next = (cnt == CW'(DIV_STEPS - 1)) ? W_ROUND : W_DIV;
      W_ROUND: state_next = (k == 2'd2) ? W_IDLE : W_PREP;
      W_IDLE:  state_next = W_IDLE;
      default: state_next = W_CHECK;
    endcase
    if (start) begin
      state_next = W_CHECK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= W_CHECK;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bad           <= 1'b0;
      clipped       <= 1'b0;
      k             <= 2'd0;
      weight_first  <= '0;
      weight_second <= '0;
      weight_third  <= '0;
    end else begin
      case (state)
        W_CHECK: begin
          bad           <= (first_time == second_time) || (first_time == third_time) ||
                           (second_time == third_time);
          clipped       <= 1'b0;
          k             <= 2'd0;
          weight_first  <= '0;
          weight_second <= '0;
          weight_third  <= '0;
        end
        W_ROUND: begin
          if (clip_now) begin
            clipped <= 1'b1;
          end
          case (k)
            2'd0:    weight_first  <= wval;
            2'd1:    weight_second <= wval;
            default: weight_third  <= wval;
          endcase
          k <= k + 2'd1;
        end
        default: ;
      endcase
    end
  end

  // Datapath registers of the divider
  always_ff @(posedge clk) begin
    case (state)
      W_PREP: begin
        x1  <= (target_time >= ta) ? target_time - ta : ta - target_time;
        x2  <= (target_time >= tb) ? target_time - tb : tb - target_time;
        y1  <= (ts >= ta) ? ts - ta : ta - ts;
        y2  <= (ts >= tb) ? ts - tb : tb - ts;
        neg <= (target_time < ta) ^ (target_time < tb) ^ (ts < ta) ^ (ts < tb);
      end
      W_MUL: begin
        num  <= PW'(x1) * PW'(x2);
        den  <= PW'(y1) * PW'(y2);
        neg  <= neg && (x1 != '0) && (x2 != '0);
        rem  <= '0;
        q    <= '0;
        over <= 1'b0;
        cnt  <= '0;
      end
      W_DIV: begin
        num <= num << 1;
        rem <= qb ? PW'(rem_sh - {1'b0, den}) : rem_sh[PW-1:0];
        if (!over) begin
          q <= q_sh;
          if (q_sh[QW-1]) begin
            over <= 1'b1;
          end
        end
        cnt <= cnt + CW'(1);
      end
      default: ;
    endcase
  end

  assign status = '{ready: state == W_IDLE, bad: bad, clipped: clipped};

endmodule

// File: rtl/core/three_point_lagrange_interpolator_top.sv
// ----------------------------------------------------------------------------
// three_point_lagrange_interpolator_top: quadratic Lagrange interpolator
// Weighted sum of three samples with weights formed from the configured times.
// ----------------------------------------------------------------------------
// Usage:
//   Write the three sample times and the target time (unsigned Q16.16) on the
//   cfg_write/cfg_index/cfg_data port while the block is idle. Each write to a
//   known index, and reset, restarts the weight unit, which forms the three
//   Lagrange weights one after another with a restoring divider. During that
//   time samples.ready stays low. Coincident times skip the divider. Then each
//   transaction on samples brings three values of one element and yields one
//   transaction on results: the weighted sum rounded to Q16.16, saturated with
//   a flag, or zero with times_invalid set. results.valid is the valid bit
//   of the last stage; a new transaction is taken every cycle while results
//   is not stalled. The four pipeline stages (input, products, sum, saturate)
//   advance together and hold when results is stalled, so samples.ready drops
//   while the last stage holds an untaken result.
//   Reset clears all valid bits and restores the reset times.
// ----------------------------------------------------------------------------
module three_point_lagrange_interpolator_top
  import tpli_pkg::*;
#(
  parameter int VALUE_WIDTH          = 32,
  parameter int TIME_WIDTH           = 32,
  parameter int WEIGHT_FRACTION_BITS = 30
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [7:0]            cfg_index,
  input  logic [TIME_WIDTH-1:0] cfg_data,
  tpli_in_if.sink               samples,
  tpli_out_if.source            results
);

  localparam int WW = WEIGHT_FRACTION_BITS + 2;
  localparam int PRW = VALUE_WIDTH + WW;
  localparam int SW = PRW + 2;
  localparam int RW = SW - WEIGHT_FRACTION_BITS;

  logic [TIME_WIDTH-1:0] first_time, second_time, third_time, target_time;
  logic signed [WW-1:0]  w1, w2, w3;
  wgt_status_t           wst;

  // Configuration registers; an unknown index is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      first_time  <= '0;
      second_time <= TIME_WIDTH'(18'h10000);
      third_time  <= TIME_WIDTH'(18'h20000);
      target_time <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FIRST_TIME:  first_time  <= cfg_data;
        REG_SECOND_TIME: second_time <= cfg_data;
        REG_THIRD_TIME:  third_time  <= cfg_data;
        REG_TARGET_TIME: target_time <= cfg_data;
        default: ;
      endcase
    end
  end

  logic start;
  assign start = cfg_write && (cfg_index <= REG_TARGET_TIME);

  tpli_weights #(
    .TIME_WIDTH          (TIME_WIDTH),
    .WEIGHT_FRACTION_BITS(WEIGHT_FRACTION_BITS)
  ) u_weights (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .first_time   (first_time),
    .second_time  (second_time),
    .third_time   (third_time),
    .target_time  (target_time),
    .weight_first (w1),
    .weight_second(w2),
    .weight_third (w3),
    .status       (wst)
  );

  // Pipeline: all stages advance together unless the output is stalled
  logic adv;
  logic v1, v2, v3, v4;
  logic signed [VALUE_WIDTH-1:0] a1, a2, a3;
  logic signed [PRW-1:0]         p1, p2, p3;
  logic signed [SW-1:0]          sum;
  logic signed [RW-1:0]          shifted;
  logic signed [VALUE_WIDTH-1:0] res;
  logic                          sat;

  assign adv           = !v4 || results.ready;
  assign samples.ready = adv && wst.ready;

  localparam logic signed [RW-1:0] MAXV = RW'({1'b0, {(VALUE_WIDTH-1){1'b1}}});
  localparam logic signed [RW-1:0] MINV = -MAXV - RW'(1);

  always_comb begin
    shifted = RW'(sum >>> WEIGHT_FRACTION_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= samples.valid && samples.ready;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // Stage 1: capture the samples
      a1 <= samples.value_first;
      a2 <= samples.value_second;
      a3 <= samples.value_third;
      // Stage 2: three signed products
      p1 <= PRW'(a1) * PRW'(w1);
      p2 <= PRW'(a2) * PRW'(w2);
      p3 <= PRW'(a3) * PRW'(w3);
      // Stage 3: sum plus half an output step, ties go up
      sum <= SW'(p1) + SW'(p2) + SW'(p3) + (SW'(1) <<< (WEIGHT_FRACTION_BITS - 1));
      // Stage 4: scale down and clip
      if (wst.bad) begin
        res <= '0;
        sat <= 1'b0;
      end else if (shifted > MAXV) begin
        res <= MAXV[VALUE_WIDTH-1:0];
        sat <= 1'b1;
      end else if (shifted < MINV) begin
        res <= MINV[VALUE_WIDTH-1:0];
        sat <= 1'b1;
      end else begin
        res <= shifted[VALUE_WIDTH-1:0];
        sat <= wst.clipped;
      end
    end
  end

  assign results.valid              = v4;
  assign results.interpolated_value = res;
  assign results.saturated          = sat;
  assign results.times_invalid      = wst.bad;

  // No transaction while the weights are being formed
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    !wst.ready |-> !samples.ready)
    else $error("samples accepted while weights are not ready");

  // A write to a known register index restarts the weight unit
  a_write_restarts: assert property (@(posedge clk) disable iff (rst)
    start |=> !wst.ready)
    else $error("weights still marked ready after a register write");

  // Coincident times give a clean zero
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.times_invalid) |->
      (results.interpolated_value == '0 && !results.saturated))
    else $error("invalid times result is not a clean zero");

  // A held result does not move
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (v4 && !results.ready) |=> (v4 && $stable(res) && $stable(sat)))
    else $error("stalled result changed");

endmodule
